/* rtl/core/aging_report_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the aging report table
// Immediate-consequence and next-cycle property forms, reset masked.
// ----------------------------------------------------------------------------
`ifndef AGING_REPORT_TABLE_ASSERT_SVH
`define AGING_REPORT_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/art_pkg.sv */
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the aging report table.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ZONE_W      = 8;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int LIVE_W      = 5;
	localparam int CFG_IDX_W   = 1;

	localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_TICK   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SWEEP  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_NONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_REFRESH = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INSERT  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_DROP    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EXPIRE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESEND = 1'b1;

	localparam logic [DATA_W-1:0] EXPIRE_RST = 32'd10000;
	localparam logic [DATA_W-1:0] RESEND_RST = 32'd1000;

	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [ZONE_W-1:0] zone;
		logic [DATA_W-1:0] distance;
		logic [DATA_W-1:0] heading;
		logic [DATA_W-1:0] updated_at;
		logic [DATA_W-1:0] sent_at;
		logic              was_sent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_U_RD,
		S_U_EV,
		S_U_MISS,
		S_P1_RD,
		S_P1_EX,
		S_P1_RS,
		S_P2_RD,
		S_P2_EV,
		S_P2_NX,
		S_OUT
	} state_t;

endpackage

/* rtl/core/art_ram.sv */
// ----------------------------------------------------------------------------
// art_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/art_age_unit.sv */
// ----------------------------------------------------------------------------
// art_age_unit
// Shared age comparator: flags when (now - stamp) mod 2^32 exceeds a limit.
// ----------------------------------------------------------------------------
module art_age_unit (
	input  logic [art_pkg::DATA_W-1:0] now_ticks,
	input  logic [art_pkg::DATA_W-1:0] stamp,
	input  logic [art_pkg::DATA_W-1:0] limit,
	output logic                       over
);

	import art_pkg::*;

	logic [DATA_W-1:0] age;

	assign age  = now_ticks - stamp;
	assign over = age > limit;

endmodule

/* rtl/core/aging_report_table.sv */
// ----------------------------------------------------------------------------
// aging_report_table
// Table of tracked entries with refresh/append, time tick and aging sweep.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only while idle. A tick
// or unused func goes from idle straight to its result word. An update
// searches the live entries in turn (one table read and one id compare
// each), adds an append-or-drop step on a miss, then gives its result word.
// A sweep runs a counting pass over the live entries (read, expiry check,
// resend check through the one shared age comparator) and a compaction
// pass (read, write back, advance); each result word waits for out_ready.
// These steps follow from the single read port of the table RAM and the
// single age comparator. Configuration writes are taken at any time.
module aging_report_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [art_pkg::DATA_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [art_pkg::FUNC_W-1:0]     func,
	input  logic [art_pkg::DATA_W-1:0]     entry_id,
	input  logic [art_pkg::ZONE_W-1:0]     zone,
	input  logic [art_pkg::DATA_W-1:0]     distance,
	input  logic [art_pkg::DATA_W-1:0]     heading,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           is_report,
	output logic [art_pkg::DATA_W-1:0]     report_id,
	output logic [art_pkg::ZONE_W-1:0]     report_zone,
	output logic [art_pkg::DATA_W-1:0]     report_distance,
	output logic [art_pkg::DATA_W-1:0]     report_heading,
	output logic [art_pkg::LIVE_W-1:0]     live_count,
	output logic [art_pkg::STATUS_W-1:0]   status,
	output logic                           last
);

	import art_pkg::*;

	state_t            state_q, state_d;

	logic [DATA_W-1:0] id_q, dist_q, head_q;
	logic [ZONE_W-1:0] zone_q;
	logic [DATA_W-1:0] now_q, expire_q, resend_q;
	logic [CNT_W-1:0]  live_q, keep_q, wp_q, rep_total_q, rep_idx_q;
	logic [IDX_W-1:0]  k_q;
	logic [TABLE_DEPTH-1:0] alive_q, due_q;
	logic              ret_sweep_q;

	logic              ram_wr_en, ram_rd_en;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	logic [DATA_W-1:0] age_stamp, age_limit;
	logic              age_over;

	logic              last_k, hit, table_full, due_now;

	art_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.wr_en(ram_wr_en),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.rd_en(ram_rd_en),
		.raddr(k_q),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	art_age_unit u_age (
		.now_ticks(now_q),
		.stamp    (age_stamp),
		.limit    (age_limit),
		.over     (age_over)
	);

	assign last_k     = (CNT_W'(k_q) + CNT_W'(1)) == live_q;
	assign hit        = ram_rdata.id == id_q;
	assign table_full = live_q >= CNT_W'(TABLE_DEPTH);
	assign due_now    = alive_q[k_q] && (!ram_rdata.was_sent || age_over);
	assign cfg_ready  = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_UPDATE: state_d = (live_q == '0) ? S_U_MISS : S_U_RD;
						FN_SWEEP:  state_d = (live_q == '0) ? S_OUT : S_P1_RD;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_U_RD:   state_d = S_U_EV;
			S_U_EV: begin
				if (hit) begin
					state_d = S_OUT;
				end else if (last_k) begin
					state_d = S_U_MISS;
				end else begin
					state_d = S_U_RD;
				end
			end
			S_U_MISS: state_d = S_OUT;
			S_P1_RD:  state_d = S_P1_EX;
			S_P1_EX:  state_d = S_P1_RS;
			S_P1_RS:  state_d = last_k ? S_P2_RD : S_P1_RD;
			S_P2_RD:  state_d = S_P2_EV;
			S_P2_EV:  state_d = due_q[k_q] ? S_OUT : S_P2_NX;
			S_P2_NX: begin
				if (!last_k) begin
					state_d = S_P2_RD;
				end else if (rep_total_q == '0) begin
					state_d = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = ret_sweep_q ? S_P2_NX : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_rd_en = 1'b0;
		ram_wr_en = 1'b0;
		ram_waddr = k_q;
		ram_wdata = ram_rdata;
		age_stamp = ram_rdata.sent_at;
		age_limit = resend_q;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_U_RD, S_P1_RD, S_P2_RD: ram_rd_en = 1'b1;
			S_U_EV: begin
				ram_wr_en            = hit;
				ram_wdata.zone       = zone_q;
				ram_wdata.distance   = dist_q;
				ram_wdata.heading    = head_q;
				ram_wdata.updated_at = now_q;
			end
			S_U_MISS: begin
				ram_wr_en            = !table_full;
				ram_waddr            = live_q[IDX_W-1:0];
				ram_wdata.id         = id_q;
				ram_wdata.zone       = zone_q;
				ram_wdata.distance   = dist_q;
				ram_wdata.heading    = head_q;
				ram_wdata.updated_at = now_q;
				ram_wdata.sent_at    = '0;
				ram_wdata.was_sent   = 1'b0;
			end
			S_P1_EX: begin
				age_stamp = ram_rdata.updated_at;
				age_limit = expire_q;
			end
			S_P2_EV: begin
				ram_wr_en = alive_q[k_q];
				ram_waddr = wp_q[IDX_W-1:0];
				if (due_q[k_q]) begin
					ram_wdata.sent_at  = now_q;
					ram_wdata.was_sent = 1'b1;
				end
			end
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			now_q       <= '0;
			expire_q    <= EXPIRE_RST;
			resend_q    <= RESEND_RST;
			k_q         <= '0;
			keep_q      <= '0;
			wp_q        <= '0;
			rep_total_q <= '0;
			rep_idx_q   <= '0;
			ret_sweep_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_EXPIRE: expire_q <= cfg_data;
					REG_RESEND: resend_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					k_q         <= '0;
					keep_q      <= '0;
					wp_q        <= '0;
					rep_total_q <= '0;
					rep_idx_q   <= '0;
					ret_sweep_q <= 1'b0;
					if (in_valid && func == FN_TICK) begin
						now_q <= now_q + DATA_W'(1);
					end
				end
				S_U_EV: begin
					if (!hit) begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_U_MISS: begin
					if (!table_full) begin
						live_q <= live_q + CNT_W'(1);
					end
				end
				S_P1_EX: begin
					if (!age_over) begin
						keep_q <= keep_q + CNT_W'(1);
					end
				end
				S_P1_RS: begin
					rep_total_q <= rep_total_q + CNT_W'(due_now);
					k_q         <= last_k ? '0 : k_q + IDX_W'(1);
				end
				S_P2_EV: begin
					if (alive_q[k_q]) begin
						wp_q <= wp_q + CNT_W'(1);
					end
					if (due_q[k_q]) begin
						rep_idx_q   <= rep_idx_q + CNT_W'(1);
						ret_sweep_q <= 1'b1;
					end
				end
				S_P2_NX: begin
					if (last_k) begin
						live_q      <= keep_q;
						ret_sweep_q <= 1'b0;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// item and result words
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				id_q   <= entry_id;
				zone_q <= zone;
				dist_q <= distance;
				head_q <= heading;
				is_report       <= 1'b0;
				report_id       <= '0;
				report_zone     <= '0;
				report_distance <= '0;
				report_heading  <= '0;
				live_count      <= LIVE_W'(live_q);
				status          <= STS_NONE;
				last            <= 1'b1;
			end
			S_U_EV: status <= STS_REFRESH;
			S_U_MISS: begin
				status     <= table_full ? STS_DROP : STS_INSERT;
				live_count <= table_full ? LIVE_W'(live_q) : LIVE_W'(live_q + CNT_W'(1));
			end
			S_P1_EX: alive_q[k_q] <= !age_over;
			S_P1_RS: due_q[k_q] <= due_now;
			S_P2_EV: begin
				is_report       <= 1'b1;
				report_id       <= ram_rdata.id;
				report_zone     <= ram_rdata.zone;
				report_distance <= ram_rdata.distance;
				report_heading  <= ram_rdata.heading;
				live_count      <= LIVE_W'(keep_q);
				status          <= STS_NONE;
				last            <= (rep_idx_q + CNT_W'(1)) == rep_total_q;
			end
			S_P2_NX: begin
				if (last_k && rep_total_q == '0) begin
					is_report       <= 1'b0;
					report_id       <= '0;
					report_zone     <= '0;
					report_distance <= '0;
					report_heading  <= '0;
					live_count      <= LIVE_W'(keep_q);
					status          <= STS_NONE;
					last            <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/art_chk.sv */
// ----------------------------------------------------------------------------
// art_chk
// Port-level checks of the aging report table, bound to the top level.
// ----------------------------------------------------------------------------
`include "aging_report_table_assert.svh"

module art_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          is_report,
	input logic [art_pkg::DATA_W-1:0]    report_id,
	input logic [art_pkg::ZONE_W-1:0]    report_zone,
	input logic [art_pkg::DATA_W-1:0]    report_distance,
	input logic [art_pkg::DATA_W-1:0]    report_heading,
	input logic [art_pkg::LIVE_W-1:0]    live_count,
	input logic [art_pkg::STATUS_W-1:0]  status,
	input logic                          last
);

	import art_pkg::*;

	`ART_ASSERT_NOW(a_one_item, out_valid, !in_ready, "new item taken while a word is pending")
	`ART_ASSERT_NEXT(a_more_words, out_valid && out_ready && !last, !in_ready, "item ended before last word")
	`ART_ASSERT_NOW(a_plain_zero, out_valid && !is_report, report_id == '0 && report_zone == '0 && report_distance == '0 && report_heading == '0, "plain word carries entry data")
	`ART_ASSERT_NOW(a_count_bound, out_valid, live_count <= LIVE_W'(TABLE_DEPTH) && (!is_report || status == STS_NONE), "bad live count or report status")
	`ART_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(report_id) && $stable(last), "stalled word changed")

endmodule

bind aging_report_table art_chk u_art_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.is_report      (is_report),
	.report_id      (report_id),
	.report_zone    (report_zone),
	.report_distance(report_distance),
	.report_heading (report_heading),
	.live_count     (live_count),
	.status         (status),
	.last           (last)
);
